[rtl/fee_pkg.sv]
// types, codes and plan helpers shared by the flash eeprom emulator
`default_nettype none
package fee_pkg;

   localparam logic [15:0] HDR_ERASED  = 16'hFFFF;
   localparam logic [15:0] HDR_ACTIVE  = 16'h0000;
   localparam logic [15:0] HDR_RECV    = 16'hEEEE;
   localparam logic [31:0] WORD_ERASED = 32'hFFFF_FFFF;

   localparam logic [1:0] PAGE_ZERO = 2'd0;
   localparam logic [1:0] PAGE_ONE  = 2'd1;
   localparam logic [1:0] NO_PAGE   = 2'd2;

   localparam logic [1:0] CMD_MOUNT  = 2'd0;
   localparam logic [1:0] CMD_READ   = 2'd1;
   localparam logic [1:0] CMD_WRITE  = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_MISS    = 2'd1;
   localparam logic [1:0] STAT_NO_PAGE = 2'd2;
   localparam logic [1:0] STAT_FULL    = 2'd3;

   localparam int NUM_VAR_REGS = 8;
   localparam int VAR_SEL_W    = 3;
   localparam int VAR_CNT_W    = 4;
   localparam int CSR_INDEX_W  = 4;
   localparam int QUEUE_DEPTH  = 5;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_NEXT, ST_SCAN, ST_SWEEP, ST_VAR, ST_VAR_WAIT, ST_DONE
   } fee_state_type;

   typedef enum logic [1:0] {
      SCAN_LOOK, SCAN_APP, SCAN_ECHK
   } scan_mode_type;

   typedef enum logic [3:0] {
      ACT_NONE, ACT_ECHK, ACT_ERASE, ACT_HDR_ACTIVE, ACT_HDR_RECV, ACT_COPY_RECV,
      ACT_COPY_FIXED, ACT_APPEND_FIRST, ACT_APPEND, ACT_LOOKUP
   } act_kind_type;

   typedef struct packed {
      act_kind_type kind;
      logic         page;
   } act_type;

   typedef act_type [QUEUE_DEPTH-1:0] plan_type;

   function automatic act_type mk_act(act_kind_type kind, logic page);
      act_type a;
      a.kind = kind;
      a.page = page;
      return a;
   endfunction

   function automatic logic [1:0] read_page_of(logic [15:0] h0, logic [15:0] h1);
      logic [1:0] p;
      if (h0 == HDR_ACTIVE) p = PAGE_ZERO;
      else if (h1 == HDR_ACTIVE) p = PAGE_ONE;
      else p = NO_PAGE;
      return p;
   endfunction

   function automatic logic [1:0] write_page_of(logic [15:0] h0, logic [15:0] h1);
      logic [1:0] p;
      if (h1 == HDR_ACTIVE) p = (h0 == HDR_RECV) ? PAGE_ZERO : PAGE_ONE;
      else if (h0 == HDR_ACTIVE) p = (h1 == HDR_RECV) ? PAGE_ONE : PAGE_ZERO;
      else p = NO_PAGE;
      return p;
   endfunction

   // header repair steps decided from the two headers at mount time
   function automatic plan_type mount_plan(logic [15:0] h0, logic [15:0] h1);
      plan_type p;
      logic fmt;
      p = '0;
      fmt = 1'b0;
      if (h0 == HDR_ERASED) begin
         if (h1 == HDR_ACTIVE) begin
            p[0] = mk_act(ACT_ECHK, 1'b0);
         end else if (h1 == HDR_RECV) begin
            p[0] = mk_act(ACT_ECHK, 1'b0);
            p[1] = mk_act(ACT_HDR_ACTIVE, 1'b1);
         end else begin
            fmt = 1'b1;
         end
      end else if (h0 == HDR_RECV) begin
         if (h1 == HDR_ACTIVE) begin
            p[0] = mk_act(ACT_COPY_RECV, 1'b0);
            p[1] = mk_act(ACT_HDR_ACTIVE, 1'b0);
            p[2] = mk_act(ACT_ECHK, 1'b1);
         end else if (h1 == HDR_ERASED) begin
            p[0] = mk_act(ACT_ECHK, 1'b1);
            p[1] = mk_act(ACT_HDR_ACTIVE, 1'b0);
         end else begin
            fmt = 1'b1;
         end
      end else if (h0 == HDR_ACTIVE) begin
         if (h1 == HDR_ACTIVE) begin
            fmt = 1'b1;
         end else if (h1 == HDR_ERASED) begin
            p[0] = mk_act(ACT_ECHK, 1'b1);
         end else begin
            p[0] = mk_act(ACT_COPY_RECV, 1'b1);
            p[1] = mk_act(ACT_HDR_ACTIVE, 1'b1);
            p[2] = mk_act(ACT_ECHK, 1'b0);
         end
      end else begin
         fmt = 1'b1;
      end
      if (fmt) begin
         p[0] = mk_act(ACT_ECHK, 1'b0);
         p[1] = mk_act(ACT_HDR_ACTIVE, 1'b0);
         p[2] = mk_act(ACT_ECHK, 1'b1);
      end
      return p;
   endfunction

   // page transfer out of the full read page
   function automatic plan_type xfer_plan(logic rp);
      plan_type p;
      p = '0;
      p[0] = mk_act(ACT_HDR_RECV, ~rp);
      p[1] = mk_act(ACT_APPEND, 1'b0);
      p[2] = mk_act(ACT_COPY_FIXED, 1'b0);
      p[3] = mk_act(ACT_ERASE, rp);
      p[4] = mk_act(ACT_HDR_ACTIVE, ~rp);
      return p;
   endfunction

endpackage
`default_nettype wire

[rtl/fee_ram.sv]
// generic single write port, single read port ram with registered read
`default_nettype none
module fee_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[rtl/two_page_flash_eeprom_emulator_unit.sv]
// Two-page flash EEPROM emulator. Both flash pages live in RAMs of PAGE_SLOTS 32-bit words;
// after reset a clearing pass erases every word of both pages, during which no command is
// taken. One command is worked at a time, one RAM word per cycle: a read scans the active
// page once, and a write that fits scans for the first erased slot. A page transfer or a
// mount that copies adds a lookup scan and an append scan per tracked variable, plus a
// scan for each page erase check and a sweep for each erase. A result is registered when
// the work ends, and the next command can be accepted while it waits.
`default_nettype none
module two_page_flash_eeprom_emulator_unit
   import fee_pkg::*;
#(
   parameter int PAGE_SLOTS = 256,
   parameter int NUM_VARS   = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [1:0]             req_cmd,
   input  wire logic [15:0]            req_var_address,
   input  wire logic [15:0]            req_write_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic      [1:0]             rsp_status,
   output logic      [15:0]            rsp_read_data,
   output logic      [1:0]             rsp_active_page,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [15:0]            csr_write_data
);

   localparam int IDX_W = $clog2(PAGE_SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(PAGE_SLOTS - 1);
   localparam logic [IDX_W-1:0] FIRST_REC = IDX_W'(1);
   localparam logic [VAR_CNT_W-1:0] VAR_END = VAR_CNT_W'(NUM_VARS);
   localparam int ACT_W = $bits(act_type);

   fee_state_type state_ff, state_in;
   plan_type      queue_ff, queue_in;
   act_kind_type  act_ff, act_in;
   scan_mode_type mode_ff, mode_in;
   logic [15:0]   addr_ff, addr_in, data_ff, data_in, key_ff, key_in, val_ff, val_in;
   logic          page_ff, page_in, recv_ff, recv_in, copy_recv_ff, copy_recv_in;
   logic [IDX_W-1:0] idx_ff, idx_in, pidx_ff, pidx_in;
   logic          pend_ff, pend_in;
   logic [VAR_CNT_W-1:0] k_ff, k_in;
   logic [1:0]    status_ff, status_in;
   logic [15:0]   rdata_ff, rdata_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in, rsp_page_ff, rsp_page_in;
   logic [15:0]   rsp_data_ff, rsp_data_in;
   logic [15:0]   var_id_ff [NUM_VAR_REGS];
   logic [15:0]   var_id_in [NUM_VAR_REGS];
   logic [31:0]   slot0_ff [2];
   logic [31:0]   slot0_in [2];

   logic [15:0] hdr0, hdr1, var_key, skip_addr;
   logic [1:0]  rp_c, wp_c;
   logic [31:0] rd0, rd1, rword, wr_data;
   logic        wr_en0, wr_en1, rd_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   logic        scan_match, scan_last, scan_hit, scan_end, is_copy, do_eval, eval_skip;
   act_type     head;

   fee_ram #(.WIDTH(32), .DEPTH(PAGE_SLOTS)) u_page0 (
      .clock(clock), .wr_en(wr_en0), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd0)
   );

   fee_ram #(.WIDTH(32), .DEPTH(PAGE_SLOTS)) u_page1 (
      .clock(clock), .wr_en(wr_en1), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd1)
   );

   assign hdr0    = slot0_ff[0][15:0];
   assign hdr1    = slot0_ff[1][15:0];
   assign rp_c    = read_page_of(hdr0, hdr1);
   assign wp_c    = write_page_of(hdr0, hdr1);
   assign rword   = page_ff ? rd1 : rd0;
   assign head    = queue_ff[0];
   assign is_copy = (act_ff == ACT_COPY_RECV) || (act_ff == ACT_COPY_FIXED);
   assign var_key = var_id_ff[k_ff[VAR_SEL_W-1:0]];

   always_comb begin
      case (mode_ff)
         SCAN_LOOK: scan_match = (rword[31:16] == key_ff);
         SCAN_APP:  scan_match = (rword == WORD_ERASED);
         SCAN_ECHK: scan_match = (rword[15:0] != HDR_ERASED);
         default:   scan_match = 1'b0;
      endcase
   end

   assign scan_last = (mode_ff == SCAN_LOOK) ? (pidx_ff == FIRST_REC) : (pidx_ff == LAST_IDX);
   assign scan_hit  = pend_ff && scan_match;
   assign scan_end  = pend_ff && !scan_match && scan_last;

   // skip address comes from slot 1 of the receiving page, or from the written address
   assign skip_addr = (state_ff == ST_VAR_WAIT) ? (recv_ff ? rd1[31:16] : rd0[31:16]) : addr_ff;
   assign do_eval   = ((state_ff == ST_VAR) && (k_ff != VAR_END) && !copy_recv_ff)
                      || (state_ff == ST_VAR_WAIT);
   assign eval_skip = (var_key == skip_addr) || (rp_c == NO_PAGE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (idx_ff == LAST_IDX) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_NEXT;
         end
         ST_NEXT: begin
            case (head.kind)
               ACT_NONE:                       state_in = ST_DONE;
               ACT_ECHK:                       state_in = ST_SCAN;
               ACT_ERASE:                      state_in = ST_SWEEP;
               ACT_COPY_RECV, ACT_COPY_FIXED:  state_in = ST_VAR;
               ACT_APPEND_FIRST, ACT_APPEND:
                  state_in = (wp_c == NO_PAGE) ? ST_DONE : ST_SCAN;
               ACT_LOOKUP:
                  state_in = (rp_c == NO_PAGE) ? ST_DONE : ST_SCAN;
               default:                        state_in = ST_NEXT;
            endcase
         end
         ST_SCAN: begin
            if (scan_hit) begin
               case (mode_ff)
                  SCAN_LOOK: begin
                     if (!is_copy) state_in = ST_DONE;
                     else if (wp_c == NO_PAGE) state_in = ST_DONE;
                  end
                  SCAN_APP: begin
                     if (act_ff == ACT_APPEND_FIRST) state_in = ST_DONE;
                     else if (act_ff == ACT_APPEND) state_in = ST_NEXT;
                     else state_in = ST_VAR;
                  end
                  default: state_in = ST_SWEEP;
               endcase
            end else if (scan_end) begin
               case (mode_ff)
                  SCAN_LOOK: state_in = is_copy ? ST_VAR : ST_DONE;
                  SCAN_APP: begin
                     if (act_ff == ACT_APPEND_FIRST && rp_c != NO_PAGE) state_in = ST_NEXT;
                     else state_in = ST_DONE;
                  end
                  default: state_in = ST_NEXT;
               endcase
            end
         end
         ST_SWEEP: begin
            if (idx_ff == LAST_IDX) state_in = ST_NEXT;
         end
         ST_VAR: begin
            if (k_ff == VAR_END) state_in = ST_NEXT;
            else if (copy_recv_ff) state_in = ST_VAR_WAIT;
            else state_in = eval_skip ? ST_VAR : ST_SCAN;
         end
         ST_VAR_WAIT: begin
            state_in = eval_skip ? ST_VAR : ST_SCAN;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath, memory control and outputs
   always_comb begin
      queue_in     = queue_ff;
      act_in       = act_ff;
      mode_in      = mode_ff;
      addr_in      = addr_ff;
      data_in      = data_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      page_in      = page_ff;
      recv_in      = recv_ff;
      copy_recv_in = copy_recv_ff;
      idx_in       = idx_ff;
      pidx_in      = pidx_ff;
      pend_in      = 1'b0;
      k_in         = k_ff;
      status_in    = status_ff;
      rdata_in     = rdata_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_page_in  = rsp_page_ff;
      var_id_in    = var_id_ff;
      slot0_in     = slot0_ff;
      wr_en0       = 1'b0;
      wr_en1       = 1'b0;
      wr_addr      = '0;
      wr_data      = WORD_ERASED;
      rd_en        = 1'b0;
      rd_addr      = '0;

      if (csr_valid && !csr_index[CSR_INDEX_W-1]) begin
         var_id_in[csr_index[VAR_SEL_W-1:0]] = csr_write_data;
      end

      case (state_ff)
         ST_CLEAR: begin
            wr_en0  = 1'b1;
            wr_en1  = 1'b1;
            wr_addr = idx_ff;
            idx_in  = (idx_ff == LAST_IDX) ? '0 : idx_ff + IDX_W'(1);
         end
         ST_IDLE: begin
            if (req_valid) begin
               addr_in   = req_var_address;
               data_in   = req_write_data;
               rdata_in  = '0;
               status_in = STAT_OK;
               queue_in  = '0;
               case (req_cmd)
                  CMD_MOUNT: queue_in = mount_plan(hdr0, hdr1);
                  CMD_READ:  queue_in[0] = mk_act(ACT_LOOKUP, 1'b0);
                  CMD_WRITE: queue_in[0] = mk_act(ACT_APPEND_FIRST, 1'b0);
                  default:   status_in = STAT_MISS;
               endcase
            end
         end
         ST_NEXT: begin
            queue_in = plan_type'(queue_ff >> ACT_W);
            act_in   = head.kind;
            case (head.kind)
               ACT_ECHK: begin
                  page_in = head.page;
                  mode_in = SCAN_ECHK;
                  idx_in  = '0;
               end
               ACT_ERASE: begin
                  page_in = head.page;
                  idx_in  = '0;
               end
               ACT_HDR_ACTIVE, ACT_HDR_RECV: begin
                  wr_en0  = !head.page;
                  wr_en1  = head.page;
                  wr_addr = '0;
                  wr_data = slot0_ff[head.page] & {16'hFFFF,
                            (head.kind == ACT_HDR_ACTIVE) ? HDR_ACTIVE : HDR_RECV};
               end
               ACT_COPY_RECV: begin
                  k_in         = '0;
                  copy_recv_in = 1'b1;
                  recv_in      = head.page;
               end
               ACT_COPY_FIXED: begin
                  k_in         = '0;
                  copy_recv_in = 1'b0;
               end
               ACT_APPEND_FIRST, ACT_APPEND: begin
                  if (wp_c == NO_PAGE) begin
                     status_in = STAT_NO_PAGE;
                  end else begin
                     page_in = wp_c[0];
                     mode_in = SCAN_APP;
                     idx_in  = '0;
                     key_in  = addr_ff;
                     val_in  = data_ff;
                  end
               end
               ACT_LOOKUP: begin
                  if (rp_c == NO_PAGE) begin
                     status_in = STAT_NO_PAGE;
                  end else begin
                     page_in = rp_c[0];
                     mode_in = SCAN_LOOK;
                     idx_in  = LAST_IDX;
                     key_in  = addr_ff;
                  end
               end
               default: ;
            endcase
         end
         ST_SCAN: begin
            rd_en   = 1'b1;
            rd_addr = idx_ff;
            pend_in = 1'b1;
            pidx_in = idx_ff;
            if (mode_ff == SCAN_LOOK) begin
               idx_in = (idx_ff == FIRST_REC) ? idx_ff : idx_ff - IDX_W'(1);
            end else begin
               idx_in = (idx_ff == LAST_IDX) ? idx_ff : idx_ff + IDX_W'(1);
            end
            if (scan_hit) begin
               case (mode_ff)
                  SCAN_LOOK: begin
                     if (!is_copy) begin
                        status_in = STAT_OK;
                        rdata_in  = rword[15:0];
                     end else if (wp_c == NO_PAGE) begin
                        status_in = STAT_NO_PAGE;
                     end else begin
                        // found the newest copy, now append it to the write page
                        val_in  = rword[15:0];
                        page_in = wp_c[0];
                        mode_in = SCAN_APP;
                        idx_in  = '0;
                        pend_in = 1'b0;
                     end
                  end
                  SCAN_APP: begin
                     wr_en0  = !page_ff;
                     wr_en1  = page_ff;
                     wr_addr = pidx_ff;
                     wr_data = {key_ff, val_ff};
                     if (is_copy) k_in = k_ff + VAR_CNT_W'(1);
                  end
                  default: begin
                     idx_in  = '0;
                     pend_in = 1'b0;
                  end
               endcase
            end else if (scan_end) begin
               case (mode_ff)
                  SCAN_LOOK: begin
                     if (is_copy) k_in = k_ff + VAR_CNT_W'(1);
                     else status_in = STAT_MISS;
                  end
                  SCAN_APP: begin
                     if (act_ff != ACT_APPEND_FIRST) status_in = STAT_FULL;
                     else if (rp_c == NO_PAGE) status_in = STAT_NO_PAGE;
                     else queue_in = xfer_plan(rp_c[0]);
                  end
                  default: ;
               endcase
            end
         end
         ST_SWEEP: begin
            wr_en0  = !page_ff;
            wr_en1  = page_ff;
            wr_addr = idx_ff;
            idx_in  = (idx_ff == LAST_IDX) ? '0 : idx_ff + IDX_W'(1);
         end
         ST_VAR: begin
            if (k_ff != VAR_END && copy_recv_ff) begin
               rd_en   = 1'b1;
               rd_addr = FIRST_REC;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_data_in   = rdata_ff;
               rsp_page_in   = rp_c;
            end
         end
         default: ;
      endcase

      if (do_eval) begin
         if (eval_skip) begin
            k_in = k_ff + VAR_CNT_W'(1);
         end else begin
            page_in = rp_c[0];
            mode_in = SCAN_LOOK;
            idx_in  = LAST_IDX;
            key_in  = var_key;
         end
      end

      // keep the slot 0 copies in step with the memories
      if (wr_en0 && wr_addr == '0) slot0_in[0] = wr_data;
      if (wr_en1 && wr_addr == '0) slot0_in[1] = wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         queue_ff     <= '0;
         act_ff       <= ACT_NONE;
         k_ff         <= '0;
         for (int i = 0; i < NUM_VAR_REGS; i++) var_id_ff[i] <= 16'hFFFF;
         slot0_ff[0]  <= WORD_ERASED;
         slot0_ff[1]  <= WORD_ERASED;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         queue_ff     <= queue_in;
         act_ff       <= act_in;
         k_ff         <= k_in;
         var_id_ff    <= var_id_in;
         slot0_ff     <= slot0_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      addr_ff       <= addr_in;
      data_ff       <= data_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      page_ff       <= page_in;
      recv_ff       <= recv_in;
      copy_recv_ff  <= copy_recv_in;
      pidx_ff       <= pidx_in;
      status_ff     <= status_in;
      rdata_ff      <= rdata_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_page_ff   <= rsp_page_in;
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_data   = rsp_data_ff;
   assign rsp_active_page = rsp_page_ff;

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !(wr_en0 || wr_en1))
      else $error("flash page written while idle");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the done state");

   a_pend_from_scan: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(state_ff == ST_SCAN))
      else $error("scan data pending without a scan read");

   a_var_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_VAR_WAIT) |-> (k_ff != VAR_END))
      else $error("variable copy ran past the tracked list");

endmodule
`default_nettype wire
